// ===== src/hbbc_pkg.sv =====
// Shared types and constants for the hashed block buffer cache.
package hbbc_pkg;
  localparam int NumSlots   = 32;
  localparam int NumBuckets = 13;
  localparam int SlotW      = 5;
  localparam int LinkW      = 6;
  localparam int BktW       = 4;
  localparam logic [LinkW-1:0] NIL_LINK  = 6'd63;
  localparam logic [31:0]      TIME_NONE = 32'hFFFF_FFFF;

  localparam logic [1:0] REQ_GET     = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_PIN     = 2'd2;
  localparam logic [1:0] REQ_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFREE  = 2'd1;
  localparam logic [1:0] ST_COUNT   = 2'd2;

  // one slot's record as stored in the slot memory
  typedef struct packed {
    logic [7:0]       dev;
    logic [31:0]      blk;
    logic [7:0]       refcnt;
    logic [31:0]      rtime;
    logic             valid;
    logic [LinkW-1:0] next;
  } slot_rec_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             hit;
    logic             fill;
    logic [1:0]       status;
  } result_t;

  // block mod NumBuckets one nibble a step, done in the controller; folds a
  // partial remainder and a 4-bit chunk with four compare-and-subtract steps
  function automatic logic [BktW-1:0] mod_step(input logic [BktW-1:0] r,
                                               input logic [3:0] d);
    logic [BktW+3:0] x;
    x = {r, d};
    for (int k = 3; k >= 0; k--) begin
      if (x >= (BktW+4)'(NumBuckets << k)) x = x - (BktW+4)'(NumBuckets << k);
    end
    return x[BktW-1:0];
  endfunction
endpackage

// ===== src/hashed_block_buffer_cache.sv =====
// Top level of the hashed block buffer cache.
// Usage: one request transfer in on in_*, one result transfer out on out_*.
// Requests: get (tag lookup with allocation/replacement), release, pin, unpin.
// After reset the slot memory is swept clear, one slot per cycle,
// and in_ready stays low during the sweep.
// One request is handled at a time; in_ready is high only while the sequencer
// is idle and the output register is empty.
// Steps from request transfer to result:
//   release/pin/unpin: read the slot, then write back its adjusted count.
//   get hit: hash the block number, then walk the home chain to the match.
//   get miss with a never-used slot left: walk the whole home chain first.
//   get miss with replacement: scan bucket chains from the home bucket on
//   until one holds an unpinned buffer; with no free buffer all are scanned.
// The next request transfer can follow in the cycle after the result transfer.
// The in_ready gate on the busy sequencer and the output register sets this.
// A stalled receiver keeps out_valid high and the result held in the sequencer; in_ready stays
// low until out_ready takes it, so nothing is lost.
module hashed_block_buffer_cache
  import hbbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [7:0]        in_device,
  input  logic [31:0]       in_block_number,
  input  logic [4:0]        in_slot_in,
  input  logic [31:0]       in_now,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [4:0]        out_slot_out,
  output logic              out_hit,
  output logic              out_needs_fill,
  output logic [1:0]        out_status
);
  logic             busy;
  logic             done;
  logic             start;
  result_t          res;
  logic             mem_we;
  logic [SlotW-1:0] mem_waddr;
  logic [SlotW-1:0] mem_raddr;
  slot_rec_t        mem_wdata;
  slot_rec_t        mem_rdata;
  logic             out_valid_r;

  assign in_ready = !busy && !out_valid_r;
  assign start    = in_valid && in_ready;

  hbbc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start),
    .req_type(in_req_type), .device(in_device), .block_number(in_block_number),
    .slot_in(in_slot_in), .now(in_now),
    .busy(busy), .done(done), .res(res),
    .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr), .mem_rdata(mem_rdata)
  );

  hbbc_slot_mem u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // result fields stay stable in the sequencer until the next request
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (done) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  assign out_valid      = out_valid_r;
  assign out_slot_out   = res.slot;
  assign out_hit        = res.hit;
  assign out_needs_fill = res.fill;
  assign out_status     = res.status;
endmodule

// ===== src/hbbc_slot_mem.sv =====
// Slot record memory: one write port, one registered read port.
module hbbc_slot_mem
  import hbbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [SlotW-1:0]     waddr,
  input  slot_rec_t            wdata,
  input  logic [SlotW-1:0]     raddr,
  output slot_rec_t            rdata
);
  slot_rec_t mem [NumSlots];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/hbbc_ctrl.sv =====
// Request sequencer: chain walks, victim search, read-modify-write of slots.
module hbbc_ctrl
  import hbbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        req_type,
  input  logic [7:0]        device,
  input  logic [31:0]       block_number,
  input  logic [SlotW-1:0]  slot_in,
  input  logic [31:0]       now,
  output logic              busy,
  output logic              done,
  output result_t           res,
  output logic              mem_we,
  output logic [SlotW-1:0]  mem_waddr,
  output slot_rec_t         mem_wdata,
  output logic [SlotW-1:0]  mem_raddr,
  input  slot_rec_t         mem_rdata
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_ADJ   = 4'd2;
  localparam logic [3:0] S_HASH  = 4'd3;
  localparam logic [3:0] S_WHEAD = 4'd4;
  localparam logic [3:0] S_WCHK  = 4'd5;
  localparam logic [3:0] S_MISS  = 4'd6;
  localparam logic [3:0] S_FWR   = 4'd7;
  localparam logic [3:0] S_SBKT  = 4'd8;
  localparam logic [3:0] S_SCHK  = 4'd9;
  localparam logic [3:0] S_VGET  = 4'd10;
  localparam logic [3:0] S_PWR   = 4'd11;

  logic [3:0]       st_r;
  logic             done_r;
  logic [1:0]       req_r;
  logic [7:0]       dev_r;
  logic [31:0]      blk_r;
  logic [SlotW-1:0] sin_r;
  logic [31:0]      now_r;
  logic [BktW-1:0]  home_r, bkt_r, nb_r;
  logic [2:0]       dig_r;
  logic [LinkW-1:0] head_r [NumBuckets];
  logic [LinkW-1:0] cur_r, prev_r, best_r, bprev_r;
  logic [31:0]      btime_r;
  logic [SlotW-1:0] n_r;
  logic [LinkW-1:0] used_r;
  logic [SlotW-1:0] clr_r;
  logic [LinkW-1:0] vnext_r;
  result_t          res_r;
  slot_rec_t        rec;
  logic             match;
  logic             walk_last;
  logic             scan_better;
  logic             scan_last;
  logic [LinkW-1:0] victim;
  logic [BktW-1:0]  bkt_inc;

  assign busy = (st_r != S_IDLE) || done_r;
  assign done = done_r;
  assign res  = res_r;
  assign rec  = mem_rdata;

  assign match       = (rec.dev == dev_r) && (rec.blk == blk_r);
  assign walk_last   = (rec.next >= LinkW'(NumSlots)) || (n_r == SlotW'(NumSlots-1));
  assign scan_last   = walk_last;
  assign scan_better = (rec.refcnt == 8'd0) && (rec.rtime < btime_r);
  assign victim      = scan_better ? cur_r : best_r;
  assign bkt_inc     = (bkt_r == BktW'(NumBuckets-1)) ? '0 : bkt_r + 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rec;
    mem_raddr = '0;
    unique case (st_r)
      S_CLR: begin
        mem_we = 1'b1; mem_waddr = clr_r;
        mem_wdata = '0;
        mem_wdata.next = NIL_LINK;
      end
      S_IDLE:  mem_raddr = slot_in;
      S_ADJ: begin
        mem_we = 1'b1; mem_waddr = sin_r;
        if (req_r == REQ_PIN) begin
          if (rec.refcnt != 8'hFF) mem_wdata.refcnt = rec.refcnt + 8'd1;
        end else if (rec.refcnt != 8'd0) begin
          mem_wdata.refcnt = rec.refcnt - 8'd1;
          if (req_r == REQ_RELEASE && rec.refcnt == 8'd1) mem_wdata.rtime = now_r;
        end
      end
      S_WHEAD: mem_raddr = head_r[home_r][SlotW-1:0];
      S_WCHK: begin
        mem_raddr = rec.next[SlotW-1:0];
        if (match) begin
          mem_we = 1'b1; mem_waddr = cur_r[SlotW-1:0];
          mem_wdata.valid = 1'b1;
          if (rec.refcnt != 8'hFF) mem_wdata.refcnt = rec.refcnt + 8'd1;
        end
      end
      S_MISS:  mem_raddr = used_r[SlotW-1:0];
      S_FWR: begin
        // fresh slot keeps its release time
        mem_we = 1'b1; mem_waddr = used_r[SlotW-1:0];
        mem_wdata.dev = dev_r; mem_wdata.blk = blk_r;
        mem_wdata.refcnt = 8'd1; mem_wdata.valid = 1'b1;
        mem_wdata.next = head_r[home_r];
      end
      S_SBKT:  mem_raddr = head_r[bkt_r][SlotW-1:0];
      S_SCHK:  mem_raddr = scan_last ? victim[SlotW-1:0] : rec.next[SlotW-1:0];
      S_VGET: begin
        mem_we = 1'b1; mem_waddr = best_r[SlotW-1:0];
        mem_wdata.dev = dev_r; mem_wdata.blk = blk_r;
        mem_wdata.refcnt = 8'd1; mem_wdata.valid = 1'b1;
        if (bkt_r != home_r) mem_wdata.next = head_r[home_r];
        mem_raddr = bprev_r[SlotW-1:0];
      end
      S_PWR: begin
        // unlink the victim from its old chain
        mem_we = 1'b1; mem_waddr = bprev_r[SlotW-1:0];
        mem_wdata.next = vnext_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; used_r <= '0; done_r <= 1'b0;
      for (int i = 0; i < NumBuckets; i++) head_r[i] <= NIL_LINK;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == SlotW'(NumSlots-1)) st_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          req_r <= req_type; dev_r <= device; blk_r <= block_number;
          sin_r <= slot_in; now_r <= now; res_r <= '0;
          dig_r <= 3'd7; home_r <= '0;
          st_r <= (req_type == REQ_GET) ? S_HASH : S_ADJ;
        end
        S_ADJ: begin
          if (req_r == REQ_PIN ? rec.refcnt == 8'hFF : rec.refcnt == 8'd0)
            res_r.status <= ST_COUNT;
          done_r <= 1'b1; st_r <= S_IDLE;
        end
        S_HASH: begin
          home_r <= mod_step(home_r, blk_r[{dig_r, 2'b00} +: 4]);
          dig_r <= dig_r - 3'd1;
          if (dig_r == 3'd0) st_r <= S_WHEAD;
        end
        S_WHEAD: begin
          cur_r <= head_r[home_r]; n_r <= '0;
          st_r <= (head_r[home_r] >= LinkW'(NumSlots)) ? S_MISS : S_WCHK;
        end
        S_WCHK: begin
          if (match) begin
            res_r.slot <= cur_r[SlotW-1:0]; res_r.hit <= 1'b1;
            res_r.fill <= !rec.valid;
            if (rec.refcnt == 8'hFF) res_r.status <= ST_COUNT;
            done_r <= 1'b1; st_r <= S_IDLE;
          end else begin
            cur_r <= rec.next; n_r <= n_r + 1'b1;
            if (walk_last) st_r <= S_MISS;
          end
        end
        S_MISS: begin
          if (used_r < LinkW'(NumSlots)) st_r <= S_FWR;
          else begin
            bkt_r <= home_r; nb_r <= '0; st_r <= S_SBKT;
          end
        end
        S_FWR: begin
          head_r[home_r] <= used_r; used_r <= used_r + 1'b1;
          res_r.slot <= used_r[SlotW-1:0]; res_r.fill <= 1'b1;
          done_r <= 1'b1; st_r <= S_IDLE;
        end
        S_SBKT: begin
          cur_r <= head_r[bkt_r]; prev_r <= NIL_LINK; best_r <= NIL_LINK;
          btime_r <= TIME_NONE; n_r <= '0;
          if (head_r[bkt_r] < LinkW'(NumSlots)) st_r <= S_SCHK;
          else if (nb_r == BktW'(NumBuckets-1)) begin
            res_r.status <= ST_NOFREE; done_r <= 1'b1; st_r <= S_IDLE;
          end else begin
            nb_r <= nb_r + 1'b1; bkt_r <= bkt_inc;
          end
        end
        S_SCHK: begin
          if (scan_better) begin
            best_r <= cur_r; bprev_r <= prev_r; btime_r <= rec.rtime;
          end
          prev_r <= cur_r; cur_r <= rec.next; n_r <= n_r + 1'b1;
          if (scan_last) begin
            if (scan_better || best_r < LinkW'(NumSlots)) st_r <= S_VGET;
            else if (nb_r == BktW'(NumBuckets-1)) begin
              res_r.status <= ST_NOFREE; done_r <= 1'b1; st_r <= S_IDLE;
            end else begin
              nb_r <= nb_r + 1'b1; bkt_r <= bkt_inc; st_r <= S_SBKT;
            end
          end
        end
        S_VGET: begin
          // victim from another bucket moves to the head of the home chain
          vnext_r <= rec.next;
          if (bkt_r != home_r) begin
            head_r[home_r] <= best_r;
            if (bprev_r >= LinkW'(NumSlots)) head_r[bkt_r] <= rec.next;
          end
          res_r.slot <= best_r[SlotW-1:0]; res_r.fill <= 1'b1;
          if (bkt_r != home_r && bprev_r < LinkW'(NumSlots)) st_r <= S_PWR;
          else begin
            done_r <= 1'b1; st_r <= S_IDLE;
          end
        end
        S_PWR: begin
          done_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
